FILE: src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  // Default configuration
  localparam int unsigned MAX_VERTICES_DEF     = 1024;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 16;

  // Field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned OUT_W      = 18;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 56;

  // Datapath widths
  localparam int unsigned EDGE_W  = POS_W + 1;
  localparam int unsigned PROD_W  = 2 * EDGE_W;
  localparam int unsigned CROSS_W = 52;
  localparam int unsigned NMAG_W  = 30;
  localparam int unsigned SQ_W    = 2 * NMAG_W;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned REM_W   = ROOT_W + 1;
  localparam int unsigned SQRT_W  = 64;
  localparam int unsigned CNT_W   = 5;

  // Root search: 32 result bits, one per cycle
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_TRI   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VRD,
    ST_EDGE,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_LD,
    ST_MAG,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_SIGN,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [POS_W-1:0] z;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } vtx_t;

  typedef struct packed {
    logic [ACC_W-1:0] z;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] x;
  } acc_t;

endpackage

FILE: src/vna_ram.sv
// ----------------------------------------------------------------------------
// vna_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vna_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/vertex_normal_accumulator_unit.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// Vertex position store and per-vertex normal accumulator. Triangles add
// their unit face normal to each corner; reads return the unit accumulated
// normal.
//
// Channel  Dir  Signals                      Content
// s_axis   in   tvalid tready tdata tuser    one request per transfer
// m_axis   out  tvalid tready tdata tuser    one result per request
//
// A zero vector skips normalization, on a read as on a degenerate triangle.
// The time a read or a triangle takes is set by the bit-serial square root,
// the restoring divider and the magnitude pre-shift (one bit a cycle). After
// reset a clearing pass zeroes the accumulator memory, one entry a cycle,
// with s_axis_tready low. A result waits in the output register, so a
// stalled m_axis does not block the next request from being taken.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit #(
  parameter int unsigned MAX_VERTICES     = vna_pkg::MAX_VERTICES_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = vna_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
  input  logic [vna_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic [vna_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // norm_x, norm_y, norm_z, zero padding
  output logic [vna_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // zero_normal
  output logic                            m_axis_tuser
);

  import vna_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned NFB = NORMAL_FRAC_BITS;
  localparam int unsigned QW  = NFB + 1;
  localparam int unsigned NW  = NFB + 2;
  localparam logic [QW-1:0] QUO_ONE = {1'b1, {NFB{1'b0}}};

  // Index helpers
  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
    logic [IDX_W+AW-1:0] e;
    e = {{AW{1'b0}}, i};
    return e[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] i);
    return (32'(i) < 32'(MAX_VERTICES));
  endfunction

  // Saturating add of a face normal component to an accumulator
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic signed [NW-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'($signed(a)) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // Input unpacking
  logic             in_xfer;
  req_e             in_req;
  logic [IDX_W-1:0] in_idx;
  vtx_t             in_pos;
  logic [IDX_W-1:0] in_ca, in_cb, in_cc;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign in_req   = req_e'(s_axis_tuser);
  assign in_idx   = s_axis_tdata[9:0];
  assign in_pos.x = s_axis_tdata[33:10];
  assign in_pos.y = s_axis_tdata[57:34];
  assign in_pos.z = s_axis_tdata[81:58];
  assign in_ca    = s_axis_tdata[91:82];
  assign in_cb    = s_axis_tdata[101:92];
  assign in_cc    = s_axis_tdata[111:102];

  // Control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]    clr_addr_q;
  logic             out_valid_q;
  logic             out_load;

  // Request registers
  req_e             req_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] corner_q [3];
  logic [IDX_W-1:0] corner_sel;

  // Datapath registers
  vtx_t                      v0_q, v1_q, v2_q;
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [EDGE_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [CROSS_W-1:0] cross_q [3];
  logic [CROSS_W-1:0]        mag_c [3];
  logic                      mag_zero;
  logic [CROSS_W-1:0]        mag_q [3];
  logic                      neg_q [3];
  logic                      big;
  logic [NMAG_W-1:0]         sq_in;
  logic [SQ_W-1:0]           sq_q;
  logic [SUM_W-1:0]          sum_q;
  logic [SQRT_W-1:0]         rs_q, root_q, bit_q, trial;
  logic [ROOT_W-1:0]         len;
  logic [REM_W-1:0]          rem_q [3];
  logic [QW-1:0]             quo_q [3];
  logic signed [NW-1:0]      res_n_q [3];
  logic                      res_z_q;
  logic signed [NW+OUT_W-1:0] norm_wide [3];
  logic [OUT_DATA_W-1:0]     out_data_q;
  logic                      out_user_q;

  // Memory ports
  logic          vtx_we, vtx_re;
  logic [AW-1:0] vtx_raddr;
  vtx_t          vtx_rdata;
  logic          acc_we, acc_re;
  logic [AW-1:0] acc_waddr, acc_raddr;
  acc_t          acc_wdata, acc_rdata;

  vna_ram #(
    .WIDTH ($bits(vtx_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (to_addr(in_idx)),
    .wdata_i (in_pos),
    .re_i    (vtx_re),
    .raddr_i (vtx_raddr),
    .rdata_o (vtx_rdata)
  );

  vna_ram #(
    .WIDTH ($bits(acc_t)),
    .DEPTH (MAX_VERTICES)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  // Corner selected by the step counter
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    corner_sel = corner_q[0];
      2'd1:    corner_sel = corner_q[1];
      default: corner_sel = corner_q[2];
    endcase
  end

  // Cross product operand selection
  always_comb begin
    unique case (cnt_q[2:0])
      3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
      3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
      3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
      3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
      3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
      default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
    endcase
  end

  // Magnitudes, shift check, square operand, root trial
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = cross_q[i][CROSS_W-1] ? CROSS_W'(-cross_q[i]) : CROSS_W'(cross_q[i]);
    end
    mag_zero = (cross_q[0] == '0) && (cross_q[1] == '0) && (cross_q[2] == '0);
    big = (|mag_q[0][CROSS_W-1:NMAG_W]) || (|mag_q[1][CROSS_W-1:NMAG_W]) ||
          (|mag_q[2][CROSS_W-1:NMAG_W]);
    unique case (cnt_q[1:0])
      2'd0:    sq_in = mag_q[0][NMAG_W-1:0];
      2'd1:    sq_in = mag_q[1][NMAG_W-1:0];
      default: sq_in = mag_q[2][NMAG_W-1:0];
    endcase
    trial = root_q + bit_q;
    len   = root_q[ROOT_W-1:0];
  end

  // Next state and memory control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    vtx_we    = 1'b0;
    vtx_re    = 1'b0;
    vtx_raddr = to_addr(corner_sel);
    acc_we    = 1'b0;
    acc_re    = 1'b0;
    acc_waddr = to_addr(corner_sel);
    acc_raddr = to_addr(corner_sel);
    acc_wdata = '0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr_q;
        if (clr_addr_q == AW'(MAX_VERTICES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_d = '0;
          unique case (in_req)
            REQ_WRITE: begin
              vtx_we  = in_range(in_idx);
              state_d = ST_RESP;
            end
            REQ_CLEAR: begin
              acc_we    = in_range(in_idx);
              acc_waddr = to_addr(in_idx);
              state_d   = ST_RESP;
            end
            REQ_READ: begin
              state_d = in_range(in_idx) ? ST_ACC_RD : ST_RESP;
            end
            default: begin
              state_d = (in_range(in_ca) && in_range(in_cb) && in_range(in_cc)) ?
                        ST_VRD : ST_RESP;
            end
          endcase
        end
      end
      ST_VRD: begin
        vtx_re = (cnt_q != CNT_W'(3));
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(3)) begin
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cnt_d   = '0;
        state_d = ST_CROSS;
      end
      ST_CROSS: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(6)) begin
          state_d = ST_MAG;
        end
      end
      ST_ACC_RD: begin
        acc_re    = 1'b1;
        acc_raddr = to_addr(idx_q);
        state_d   = ST_ACC_LD;
      end
      ST_ACC_LD: begin
        state_d = ST_MAG;
      end
      ST_MAG: begin
        state_d = mag_zero ? ST_RESP : ST_SHIFT;
      end
      ST_SHIFT: begin
        if (!big) begin
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(3)) begin
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NFB)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cnt_d   = '0;
        state_d = (req_q == REQ_TRI) ? ST_UPD_RD : ST_RESP;
      end
      ST_UPD_RD: begin
        acc_re  = 1'b1;
        state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        acc_we      = 1'b1;
        acc_wdata.x = sat_add(acc_rdata.x, res_n_q[0]);
        acc_wdata.y = sat_add(acc_rdata.y, res_n_q[1]);
        acc_wdata.z = sat_add(acc_rdata.z, res_n_q[2]);
        if (cnt_q == CNT_W'(2)) begin
          state_d = ST_RESP;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_UPD_RD;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          req_q       <= in_req;
          idx_q       <= in_idx;
          corner_q[0] <= in_ca;
          corner_q[1] <= in_cb;
          corner_q[2] <= in_cc;
          for (int i = 0; i < 3; i++) begin
            res_n_q[i] <= '0;
          end
          res_z_q <= (in_req == REQ_READ) && !in_range(in_idx);
        end
      end
      ST_VRD: begin
        unique case (cnt_q[1:0])
          2'd1:    v0_q <= vtx_rdata;
          2'd2:    v1_q <= vtx_rdata;
          2'd3:    v2_q <= vtx_rdata;
          default: ;
        endcase
      end
      ST_EDGE: begin
        e1_q[0] <= EDGE_W'($signed(v2_q.x)) - EDGE_W'($signed(v0_q.x));
        e1_q[1] <= EDGE_W'($signed(v2_q.y)) - EDGE_W'($signed(v0_q.y));
        e1_q[2] <= EDGE_W'($signed(v2_q.z)) - EDGE_W'($signed(v0_q.z));
        e2_q[0] <= EDGE_W'($signed(v1_q.x)) - EDGE_W'($signed(v0_q.x));
        e2_q[1] <= EDGE_W'($signed(v1_q.y)) - EDGE_W'($signed(v0_q.y));
        e2_q[2] <= EDGE_W'($signed(v1_q.z)) - EDGE_W'($signed(v0_q.z));
      end
      ST_CROSS: begin
        // one product a cycle, folded into its component the cycle after
        prod_q <= mul_a * mul_b;
        unique case (cnt_q[2:0])
          3'd1:    cross_q[0] <= CROSS_W'(prod_q);
          3'd2:    cross_q[0] <= cross_q[0] - CROSS_W'(prod_q);
          3'd3:    cross_q[1] <= CROSS_W'(prod_q);
          3'd4:    cross_q[1] <= cross_q[1] - CROSS_W'(prod_q);
          3'd5:    cross_q[2] <= CROSS_W'(prod_q);
          3'd6:    cross_q[2] <= cross_q[2] - CROSS_W'(prod_q);
          default: ;
        endcase
      end
      ST_ACC_LD: begin
        cross_q[0] <= CROSS_W'($signed(acc_rdata.x));
        cross_q[1] <= CROSS_W'($signed(acc_rdata.y));
        cross_q[2] <= CROSS_W'($signed(acc_rdata.z));
      end
      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= mag_c[i];
          neg_q[i] <= cross_q[i][CROSS_W-1];
        end
        res_z_q <= mag_zero;
      end
      ST_SHIFT: begin
        // bring the largest magnitude below 2^30, one bit a cycle
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end
        sum_q <= '0;
      end
      ST_SQ: begin
        sq_q <= sq_in * sq_in;
        if (cnt_q != '0) begin
          sum_q <= sum_q + SUM_W'(sq_q);
        end
        if (cnt_q == CNT_W'(3)) begin
          rs_q   <= SQRT_W'(sum_q + SUM_W'(sq_q));
          root_q <= '0;
          bit_q  <= SQRT_W'(1) << (SQRT_W - 2);
        end
      end
      ST_SQRT: begin
        if (rs_q >= trial) begin
          rs_q   <= rs_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= REM_W'(mag_q[i][NMAG_W-1:0]);
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per lane a cycle
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= REM_W'(len)) begin
            rem_q[i] <= (rem_q[i] - REM_W'(len)) << 1;
            quo_q[i] <= {quo_q[i][QW-2:0], 1'b1};
          end else begin
            rem_q[i] <= rem_q[i] << 1;
            quo_q[i] <= {quo_q[i][QW-2:0], 1'b0};
          end
        end
      end
      ST_SIGN: begin
        for (int i = 0; i < 3; i++) begin
          res_n_q[i] <= neg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
        end
      end
      default: ;
    endcase
  end

  // Result formatting
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_wide[i] = (req_q == REQ_READ) ? (NW+OUT_W)'(res_n_q[i]) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {2'b00, norm_wide[2][OUT_W-1:0], norm_wide[1][OUT_W-1:0],
                     norm_wide[0][OUT_W-1:0]};
      out_user_q <= res_z_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Checks
  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("request taken during accumulator clearing pass");

  a_acc_port_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_we && acc_re))
    else $error("accumulator read and write in the same cycle");

  a_div_nonzero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (len != '0))
    else $error("division by zero length");

  a_quo_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |->
      (quo_q[0] <= QUO_ONE) && (quo_q[1] <= QUO_ONE) && (quo_q[2] <= QUO_ONE))
    else $error("normalized component above one");

endmodule
